/* rtl/core/jsu_pkg.sv */
package jsu_pkg;

	// error codes carried on error_code
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_ESCAPE = 2'd1;
	localparam logic [1:0] ERR_HEX    = 2'd2;
	localparam logic [1:0] ERR_UNTERM = 2'd3;

	// characters the decoder looks at
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6e;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_U  = 8'h75;

	// control characters that escapes decode to
	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_FF = 8'h0c;
	localparam logic [7:0] CTL_LF = 8'h0a;
	localparam logic [7:0] CTL_CR = 8'h0d;
	localparam logic [7:0] CTL_HT = 8'h09;

	// hex digit lookup: ok flag and nibble value
	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] b);
		hex_digit_t r;
		r.ok  = 1'b0;
		r.nib = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r.ok  = 1'b1;
			r.nib = 4'(b - 8'h30);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r.ok  = 1'b1;
			r.nib = 4'(b - 8'h37);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r.ok  = 1'b1;
			r.nib = 4'(b - 8'h57);
		end
		return r;
	endfunction

endpackage

/* rtl/core/json_string_unescape_unit.sv */
// path: a byte goes from the input register through the decoder into the result register
// throughput: one byte per cycle; the input register and the result
// register each advance every cycle unless the result side stalls
// reset: arst_n clears the decoder to idle outside any string and drops
// both valid flags; payload registers are not reset
module json_string_unescape_unit import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       last_of_input,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       byte_valid,
	output logic [7:0] out_byte,
	output logic       string_done,
	output logic       binary_seen,
	output logic [1:0] error_code
);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_STRING,
		MODE_ESCAPE,
		MODE_HEX
	} mode_t;

	mode_t      mode_q, mode_d;
	logic [1:0] left_q, left_d;
	logic [7:0] acc_q, acc_d;
	logic       zflag_q, zflag_d;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic       advance;
	logic       fire;
	logic       r_bvalid, r_done, r_bin;
	logic [7:0] r_byte;
	logic [1:0] r_err;
	hex_digit_t hd;
	logic [7:0] acc_next;

	// the input stage moves on when the result register is free
	assign advance  = vld_s1 && (!out_valid || out_ready);
	assign in_ready = !vld_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= last_of_input;
		end
	end

	assign hd       = hex_decode(byte_s1);
	assign acc_next = {acc_q[3:0], hd.nib};

	// decode one byte against the current mode
	always_comb begin
		mode_d   = mode_q;
		left_d   = left_q;
		acc_d    = acc_q;
		zflag_d  = zflag_q;
		fire     = 1'b0;
		r_bvalid = 1'b0;
		r_byte   = 8'd0;
		r_done   = 1'b0;
		r_bin    = 1'b0;
		r_err    = ERR_NONE;
		if (mode_q == MODE_IDLE) begin
			if (byte_s1 == CH_QUOTE) begin
				left_d  = 2'd0;
				acc_d   = 8'd0;
				zflag_d = 1'b0;
				if (last_s1) begin
					fire  = 1'b1;
					r_err = ERR_UNTERM;
				end else begin
					mode_d = MODE_STRING;
				end
			end
		end else if (last_s1 && !(byte_s1 == CH_QUOTE && mode_q != MODE_ESCAPE)) begin
			// input ends with the string still open
			mode_d  = MODE_IDLE;
			left_d  = 2'd0;
			acc_d   = 8'd0;
			zflag_d = 1'b0;
			fire    = 1'b1;
			r_err   = ERR_UNTERM;
		end else begin
			case (mode_q)
				MODE_STRING: begin
					if (byte_s1 == CH_QUOTE) begin
						fire    = 1'b1;
						r_done  = 1'b1;
						r_bin   = zflag_q;
						mode_d  = MODE_IDLE;
						left_d  = 2'd0;
						acc_d   = 8'd0;
						zflag_d = 1'b0;
					end else if (byte_s1 == CH_BSLASH) begin
						mode_d = MODE_ESCAPE;
					end else begin
						fire     = 1'b1;
						r_bvalid = 1'b1;
						r_byte   = byte_s1;
					end
				end
				MODE_ESCAPE: begin
					mode_d   = MODE_STRING;
					fire     = 1'b1;
					r_bvalid = 1'b1;
					case (byte_s1)
						CH_QUOTE, CH_BSLASH, CH_SLASH: r_byte = byte_s1;
						CH_LOW_B: r_byte = CTL_BS;
						CH_LOW_F: r_byte = CTL_FF;
						CH_LOW_N: r_byte = CTL_LF;
						CH_LOW_R: r_byte = CTL_CR;
						CH_LOW_T: r_byte = CTL_HT;
						CH_LOW_U: begin
							fire     = 1'b0;
							r_bvalid = 1'b0;
							mode_d   = MODE_HEX;
							left_d   = 2'd3;
							acc_d    = 8'd0;
						end
						default: begin
							r_bvalid = 1'b0;
							r_err    = ERR_ESCAPE;
							mode_d   = MODE_IDLE;
							left_d   = 2'd0;
							acc_d    = 8'd0;
							zflag_d  = 1'b0;
						end
					endcase
				end
				MODE_HEX: begin
					if (!hd.ok) begin
						fire    = 1'b1;
						r_err   = ERR_HEX;
						mode_d  = MODE_IDLE;
						left_d  = 2'd0;
						acc_d   = 8'd0;
						zflag_d = 1'b0;
					end else if (left_q != 2'd0) begin
						acc_d  = acc_next;
						left_d = left_q - 2'd1;
					end else begin
						// last digit: emit the low byte of the code point
						fire     = 1'b1;
						r_bvalid = 1'b1;
						r_byte   = acc_next;
						if (acc_next == 8'd0) begin
							zflag_d = 1'b1;
						end
						mode_d = MODE_STRING;
						acc_d  = 8'd0;
					end
				end
				default: begin
					mode_d = MODE_IDLE;
				end
			endcase
		end
	end

	// decoder state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			left_q    <= 2'd0;
			acc_q     <= 8'd0;
			zflag_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (advance) begin
				mode_q  <= mode_d;
				left_q  <= left_d;
				acc_q   <= acc_d;
				zflag_q <= zflag_d;
			end
			if (advance) begin
				out_valid <= fire;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && fire) begin
			byte_valid  <= r_bvalid;
			out_byte    <= r_byte;
			string_done <= r_done;
			binary_seen <= r_bin;
			error_code  <= r_err;
		end
	end

endmodule

/* rtl/core/jsu_checker.sv */
module jsu_checker import jsu_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       byte_valid,
	input logic [7:0] out_byte,
	input logic       string_done,
	input logic       binary_seen,
	input logic [1:0] error_code
);

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(byte_valid) && $stable(string_done) && $stable(error_code))
		else $error("result changed while stalled");

	// an error result carries no byte and no string end
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> !byte_valid && !string_done && !binary_seen)
		else $error("error result carries data");

	// binary flag only comes with the closing quote
	a_bin_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && binary_seen |-> string_done && !byte_valid)
		else $error("binary flag without string end");

	// every result means exactly one thing: a byte, a string end or an error
	a_meaning: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({byte_valid, string_done, error_code != ERR_NONE}) == 1)
		else $error("result with no or mixed meaning");

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.byte_valid  (byte_valid),
	.out_byte    (out_byte),
	.string_done (string_done),
	.binary_seen (binary_seen),
	.error_code  (error_code)
);
